// ===== hdl/triple_buffered_frame_store_core_defines.svh =====
// Assertion macros for the frame store core.
// Taken in by the top level with `include; no other dependencies.
`ifndef TRIPLE_BUFFERED_FRAME_STORE_CORE_DEFINES_SVH
`define TRIPLE_BUFFERED_FRAME_STORE_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define TBFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define TBFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tbfs_pkg.sv =====
// Package for the triple-buffered frame store: item structs, command codes,
// register indexes and blank bytes. No dependencies.
package tbfs_pkg;

    typedef enum logic [3:0] {
        REQ_SET_PIXEL   = 4'd0,
        REQ_CLEAR_PIXEL = 4'd1,
        REQ_WRITE_BYTE  = 4'd2,
        REQ_TEST_PIXEL  = 4'd3,
        REQ_CLEAR_FRAME = 4'd4,
        REQ_COPY        = 4'd5,
        REQ_COMPARE     = 4'd6,
        REQ_PUBLISH     = 4'd7,
        REQ_SOF         = 4'd8,
        REQ_READ_BYTE   = 4'd9
    } t_req;

    localparam logic [3:0] CFG_PANEL_MODE    = 4'd0;
    localparam logic [3:0] CFG_TRIPLE_ENABLE = 4'd1;

    localparam logic [7:0] BLANK_ACTIVE_HIGH = 8'h00;
    localparam logic [7:0] BLANK_ACTIVE_LOW  = 8'hFF;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic       status;
        logic       pixel_lit;
        logic       frames_match;
        logic [7:0] stored_byte;
        logic [1:0] shown_frame;
    } t_out;

endpackage

// ===== hdl/tbfs_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module tbfs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 240,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [WIDTH-1:0]  o_rdata_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/triple_buffered_frame_store_core.sv =====
// Top level of the triple-buffered monochrome frame store.
// Depends on tbfs_pkg, tbfs_ram and triple_buffered_frame_store_core_defines.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | in        | i_in_valid / o_in_ready   | i_in  (tbfs_pkg::t_in)
//  out     | out       | o_out_valid / i_out_ready | o_out (tbfs_pkg::t_out)
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data[0]
//
// Pixel, byte, test and read byte items in range take a memory read, then a
// write-back or the result; out-of-range coordinates, publish, start of frame
// and unused codes give their result straight from the accepting state. Clear
// frame, copy and compare walk one byte per cycle through the frame memory's ports.
// After reset a clearing pass zeroes the whole memory; no item is taken during
// it. A stalled result waits in the output register (or in a holding register)
// while no new item is taken; configuration writes are still applied.
module triple_buffered_frame_store_core #(
    parameter int ROWS      = 16,
    parameter int COL_BYTES = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tbfs_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tbfs_pkg::t_out   o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [3:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

`include "triple_buffered_frame_store_core_defines.svh"

    // frame geometry: three frames back to back in one memory
    localparam int FB    = ROWS * COL_BYTES;
    localparam int DEPTH = 3 * FB;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] BASE1     = AW'(FB);
    localparam logic [AW-1:0] BASE2     = AW'(2 * FB);
    localparam logic [AW-1:0] FB_LAST   = AW'(FB - 1);
    localparam logic [AW-1:0] FB_END    = AW'(FB);
    localparam logic [AW-1:0] MEM_LAST  = AW'(DEPTH - 1);
    localparam logic [8:0]    X_LIMIT   = 9'(8 * COL_BYTES);
    localparam logic [8:0]    Y_LIMIT   = 9'(ROWS);
    localparam logic [4:0]    COL_LAST  = 5'(COL_BYTES - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_FILL,
        S_COPY,
        S_CMP,
        S_PUSH
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_addr, n_addr;
    logic [3:0]      r_req, n_req;
    logic [2:0]      r_bit, n_bit;
    logic [7:0]      r_bv, n_bv;
    logic            r_diff, n_diff;
    tbfs_pkg::t_out  r_res, n_res;
    tbfs_pkg::t_out  r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_rsel, n_rsel;
    logic [1:0]      r_wsel, n_wsel;
    logic [1:0]      r_isel, n_isel;
    logic            r_pend, n_pend;
    logic            r_pm, n_pm;
    logic            r_triple, n_triple;

    // memory ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr_a;
    logic [AW-1:0]   ram_raddr_b;
    logic [7:0]      ram_rdata_a;
    logic [7:0]      ram_rdata_b;

    // address decode of the incoming item
    logic            in_range;
    logic [4:0]      col;
    logic [15:0]     off_wide;
    logic [AW-1:0]   w_base;
    logic [AW-1:0]   r_base;
    logic [AW-1:0]   acc_addr;
    logic            slot_free;
    logic            in_acc;
    logic [7:0]      mask;
    logic            done;
    tbfs_pkg::t_out  done_res;

    // checker terms
    logic            sel_distinct;
    logic            publish_acc;

    function automatic logic [AW-1:0] base_of(input logic [1:0] sel);
        logic [AW-1:0] b;
        unique case (sel)
            2'd1:    b = BASE1;
            2'd2:    b = BASE2;
            default: b = '0;
        endcase
        return b;
    endfunction

    tbfs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .o_rdata_a(ram_rdata_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_b(ram_rdata_b)
    );

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && slot_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_base   = base_of(r_wsel);
    assign r_base   = base_of(r_rsel);
    assign in_range = ({1'b0, i_in.x_pos} < X_LIMIT) && ({1'b0, i_in.y_pos} < Y_LIMIT);
    // active-low panels store columns in reversed byte order
    assign col      = r_pm ? (COL_LAST - i_in.x_pos[7:3]) : i_in.x_pos[7:3];
    assign off_wide = 16'(i_in.y_pos) * 16'(COL_BYTES) + 16'(col);
    assign acc_addr = ((i_in.req_type == tbfs_pkg::REQ_TEST_PIXEL)
                       || (i_in.req_type == tbfs_pkg::REQ_READ_BYTE) ? r_base : w_base)
                      + off_wide[AW-1:0];
    // LSB-first on active-low panels, MSB-first otherwise
    assign mask     = r_pm ? (8'h01 << r_bit) : (8'h80 >> r_bit);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_req       = r_req;
        n_bit       = r_bit;
        n_bv        = r_bv;
        n_diff      = r_diff;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rsel      = r_rsel;
        n_wsel      = r_wsel;
        n_isel      = r_isel;
        n_pend      = r_pend;
        n_pm        = r_pm;
        n_triple    = r_triple;

        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_raddr_a = r_addr;
        ram_raddr_b = r_addr;

        done        = 1'b0;
        done_res    = '0;
        done_res.shown_frame = r_rsel;

        if (i_cfg_valid) begin
            if (i_cfg_index == tbfs_pkg::CFG_PANEL_MODE) begin
                n_pm = i_cfg_data[0];
            end else if (i_cfg_index == tbfs_pkg::CFG_TRIPLE_ENABLE) begin
                n_triple = i_cfg_data[0];
            end
        end

        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = tbfs_pkg::BLANK_ACTIVE_HIGH;
                if (r_cnt == MEM_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_req  = i_in.req_type;
                    n_bit  = i_in.x_pos[2:0];
                    n_bv   = i_in.byte_value;
                    n_addr = acc_addr;
                    n_cnt  = '0;
                    n_diff = 1'b0;
                    unique case (i_in.req_type)
                        tbfs_pkg::REQ_SET_PIXEL, tbfs_pkg::REQ_CLEAR_PIXEL,
                        tbfs_pkg::REQ_WRITE_BYTE, tbfs_pkg::REQ_TEST_PIXEL,
                        tbfs_pkg::REQ_READ_BYTE: begin
                            if (in_range) begin
                                ram_raddr_a = acc_addr;
                                n_state     = S_RMW;
                            end else begin
                                done            = 1'b1;
                                done_res.status = 1'b1;
                            end
                        end
                        tbfs_pkg::REQ_CLEAR_FRAME: n_state = S_FILL;
                        tbfs_pkg::REQ_COPY:        n_state = S_COPY;
                        tbfs_pkg::REQ_COMPARE:     n_state = S_CMP;
                        tbfs_pkg::REQ_PUBLISH: begin
                            if (!r_triple) begin
                                n_rsel = r_wsel;
                                n_wsel = r_rsel;
                            end else begin
                                n_isel = r_wsel;
                                n_wsel = r_isel;
                                n_pend = 1'b1;
                            end
                            done                 = 1'b1;
                            done_res.shown_frame = n_rsel;
                        end
                        tbfs_pkg::REQ_SOF: begin
                            if (r_triple && r_pend) begin
                                n_pend = 1'b0;
                                n_rsel = r_isel;
                                n_isel = r_rsel;
                            end
                            done                 = 1'b1;
                            done_res.shown_frame = n_rsel;
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            S_RMW: begin
                ram_waddr = r_addr;
                done      = 1'b1;
                unique case (r_req)
                    tbfs_pkg::REQ_SET_PIXEL: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_pm ? (ram_rdata_a & ~mask) : (ram_rdata_a | mask);
                    end
                    tbfs_pkg::REQ_CLEAR_PIXEL: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_pm ? (ram_rdata_a | mask) : (ram_rdata_a & ~mask);
                    end
                    tbfs_pkg::REQ_WRITE_BYTE: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_pm ? ~r_bv : r_bv;
                    end
                    tbfs_pkg::REQ_TEST_PIXEL: begin
                        done_res.pixel_lit = (|(ram_rdata_a & mask)) ^ r_pm;
                    end
                    default: begin
                        done_res.stored_byte = ram_rdata_a;
                    end
                endcase
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = w_base + r_cnt;
                ram_wdata = r_pm ? tbfs_pkg::BLANK_ACTIVE_LOW : tbfs_pkg::BLANK_ACTIVE_HIGH;
                if (r_cnt == FB_LAST) begin
                    done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_COPY: begin
                // read byte k of the read frame, write byte k-1 of the write frame
                ram_raddr_a = r_base + r_cnt;
                if (r_cnt != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_base + r_cnt - 1'b1;
                    ram_wdata = ram_rdata_a;
                end
                if (r_cnt == FB_END) begin
                    done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CMP: begin
                ram_raddr_a = w_base + r_cnt;
                ram_raddr_b = r_base + r_cnt;
                if (r_cnt != '0) begin
                    n_diff = r_diff || (ram_rdata_a != ram_rdata_b);
                end
                if (r_cnt == FB_END) begin
                    done                  = 1'b1;
                    done_res.frames_match = !(r_diff || (ram_rdata_a != ram_rdata_b));
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PUSH: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // result goes straight out when the output slot is free, else it is held
        if (done) begin
            if (slot_free) begin
                n_out       = done_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = done_res;
                n_state = S_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_rsel      <= 2'd0;
            r_wsel      <= 2'd1;
            r_isel      <= 2'd2;
            r_pend      <= 1'b0;
            r_pm        <= 1'b0;
            r_triple    <= 1'b1;
            r_diff      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_rsel      <= n_rsel;
            r_wsel      <= n_wsel;
            r_isel      <= n_isel;
            r_pend      <= n_pend;
            r_pm        <= n_pm;
            r_triple    <= n_triple;
            r_diff      <= n_diff;
        end
        r_addr <= n_addr;
        r_req  <= n_req;
        r_bit  <= n_bit;
        r_bv   <= n_bv;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign sel_distinct = (r_rsel != r_wsel) && (r_rsel != r_isel) && (r_wsel != r_isel)
                          && (r_rsel != 2'd3) && (r_wsel != 2'd3) && (r_isel != 2'd3);
    assign publish_acc  = in_acc && r_triple && (i_in.req_type == tbfs_pkg::REQ_PUBLISH);

    // frame selectors always name three distinct frames
    `TBFS_ASSERT_IMP(a_sel_distinct, i_clk, i_rst_n, 1'b1, sel_distinct, "frame selectors collide")
    // the memory is never written while waiting for an item
    `TBFS_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !ram_we, "idle write")
    // a triple-buffered publish leaves a frame pending
    `TBFS_ASSERT_NXT(a_publish_pending, i_clk, i_rst_n, publish_acc, r_pend, "no pending frame")

endmodule
